// ===== rtl/pvd_pkg.sv =====
// package with the decoder's types and prefix constants
package pvd_pkg;

  localparam logic [7:0] PREFIX_ONE   = 8'h80;
  localparam logic [7:0] PREFIX_TWO   = 8'hC0;
  localparam logic [7:0] PREFIX_THREE = 8'hE0;

  localparam logic [2:0] LEN_14 = 3'd2;
  localparam logic [2:0] LEN_29 = 3'd4;
  localparam logic [2:0] LEN_32 = 3'd5;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_14   = 2'd1,
    KIND_29   = 2'd2,
    KIND_32   = 2'd3
  } code_kind_t;

  typedef struct packed {
    logic [2:0]  byte_phase;
    code_kind_t  code_kind;
    logic [31:0] partial_value;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    logic [2:0]  bytes_used;
  } dec_result_t;

endpackage

// ===== rtl/pvd_if.sv =====
// stream interfaces for the byte input and the decoded value output
interface pvd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface pvd_value_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  bytes_used;

  modport source (output valid, output value, output bytes_used, input ready);
  modport sink (input valid, input value, input bytes_used, output ready);
endinterface

// ===== rtl/prefix_varint_decoder.sv =====
// prefix varint decoder: out valid rises in the cycle after the final byte of a value is taken
// throughput one byte per cycle while the output is not stalled, set by the registered state update per byte
// input stalls only while the output register holds a value that is not taken
// synchronous active-low reset clears the byte phase, code kind and output valid
// top level of the prefix varint decoder
module prefix_varint_decoder (
  input logic         clk,
  input logic         rst_n,
  pvd_byte_if.sink    in_chan,
  pvd_value_if.source out_chan
);
  import pvd_pkg::*;

  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t result;
  logic        accept;
  logic        free;

  assign in_chan.ready = free;
  assign accept        = in_chan.valid && free;

  pvd_step u_step (
    .state      (state_r),
    .data_byte  (in_chan.data_byte),
    .buffer_end (in_chan.buffer_end),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.byte_phase    <= 3'd0;
      state_r.code_kind     <= KIND_NONE;
      state_r.partial_value <= 32'h0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  pvd_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .result         (result),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_value      (out_chan.value),
    .out_bytes_used (out_chan.bytes_used),
    .free           (free)
  );

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_phase <= 3'd4)
    else $error("byte phase out of range");

  a_kind_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.byte_phase != 3'd0) |-> (state_r.code_kind != KIND_NONE))
    else $error("mid-value phase without a code kind");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.buffer_end) |=> (state_r.byte_phase == 3'd0 && out_chan.valid))
    else $error("end-of-buffer byte did not close the value");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.bytes_used >= 3'd1 && out_chan.bytes_used <= 3'd5))
    else $error("bytes used out of range");
`endif

endmodule

// ===== rtl/pvd_step.sv =====
// next-state and result logic for one stream byte
module pvd_step (
  input  pvd_pkg::dec_state_t  state,
  input  logic [7:0]           data_byte,
  input  logic                 buffer_end,
  output pvd_pkg::dec_state_t  state_nxt,
  output pvd_pkg::dec_result_t result
);
  import pvd_pkg::*;

  logic [31:0] shifted;
  logic [2:0]  count;
  logic [2:0]  total;
  logic [2:0]  gap;
  code_kind_t  kind_first;

  always_comb begin
    shifted = {state.partial_value[23:0], data_byte};
    count   = state.byte_phase + 3'd1;
    case (state.code_kind)
      KIND_14: total = LEN_14;
      KIND_29: total = LEN_29;
      default: total = LEN_32;
    endcase
    gap = total - count;

    if ((data_byte & PREFIX_THREE) == PREFIX_THREE) begin
      kind_first = KIND_32;
    end else if ((data_byte & PREFIX_TWO) == PREFIX_TWO) begin
      kind_first = KIND_29;
    end else begin
      kind_first = KIND_14;
    end

    state_nxt         = state;
    result.emit       = 1'b0;
    result.value      = shifted;
    result.bytes_used = count;

    if (state.byte_phase == 3'd0) begin
      result.bytes_used = 3'd1;
      if ((data_byte & PREFIX_ONE) == 8'h00) begin
        result.emit  = 1'b1;
        result.value = {24'h0, data_byte};
      end else begin
        state_nxt.code_kind = kind_first;
        case (kind_first)
          KIND_29: state_nxt.partial_value = {27'h0, data_byte[4:0]};
          KIND_14: state_nxt.partial_value = {26'h0, data_byte[5:0]};
          default: state_nxt.partial_value = 32'h0;
        endcase
        state_nxt.byte_phase = 3'd1;
        // a cut 14-bit code gives back the raw first byte
        result.emit  = buffer_end;
        result.value = (kind_first == KIND_14) ? {24'h0, data_byte} : 32'h0;
      end
    end else begin
      state_nxt.partial_value = shifted;
      state_nxt.byte_phase    = count;
      if (count >= total) begin
        result.emit = 1'b1;
      end else if (buffer_end) begin
        // missing trailing bytes count as zero
        result.emit = 1'b1;
        case (gap)
          3'd1:    result.value = {shifted[23:0], 8'h0};
          3'd2:    result.value = {shifted[15:0], 16'h0};
          3'd3:    result.value = {shifted[7:0], 24'h0};
          default: result.value = shifted;
        endcase
      end
    end

    if (result.emit) begin
      state_nxt.byte_phase = 3'd0;
    end
  end

endmodule

// ===== rtl/pvd_out_reg.sv =====
// output register holding one decoded value until it is taken
module pvd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  pvd_pkg::dec_result_t result,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [31:0]          out_value,
  output logic [2:0]           out_bytes_used,
  output logic                 free
);
  import pvd_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] value_r;
  logic [2:0]  used_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load && result.emit) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && result.emit) begin
      value_r <= result.value;
      used_r  <= result.bytes_used;
    end
  end

  assign out_valid      = valid_r;
  assign out_value      = value_r;
  assign out_bytes_used = used_r;

endmodule

// ===== sim/prefix_varint_decoder_test.sv =====
// testbench for the prefix varint decoder: directed table, random byte streams, value check
module prefix_varint_decoder_test;
  import pvd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BYTES   = 1700;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  used;
  } decoded_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [31:0] value;
    logic [2:0]  used;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;
  int   errors = 0;

  decoded_t expected_values[$];

  // decoder state as seen by the predictor
  logic [2:0]  dec_phase = 3'd0;
  code_kind_t  dec_kind = KIND_NONE;
  logic [7:0]  dec_first = 8'd0;
  logic [31:0] dec_partial = 32'd0;

  // typed rows carry their result, the rest go through the predictor
  stim_row_t directed_rows [23] = '{
    '{8'h00, 1'b0, 1'b1, 32'h0000_0000, 3'd1},
    '{8'h7F, 1'b1, 1'b1, 32'h0000_007F, 3'd1},
    '{8'h80, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'h00, 1'b0, 1'b1, 32'h0000_0000, 3'd2},
    '{8'hBF, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b0, 1'b1, 32'h0000_3FFF, 3'd2},
    '{8'hA5, 1'b1, 1'b1, 32'h0000_00A5, 3'd1},
    '{8'hDF, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b0, 1'b1, 32'h1FFF_FFFF, 3'd4},
    '{8'hC3, 1'b1, 1'b1, 32'h0000_0000, 3'd1},
    '{8'hC1, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'h12, 1'b1, 1'b1, 32'h0112_0000, 3'd2},
    '{8'hE0, 1'b1, 1'b1, 32'h0000_0000, 3'd1},
    '{8'hE0, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 3'd5},
    '{8'hE5, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'h12, 1'b0, 1'b0, 32'h0, 3'd0},
    '{8'h34, 1'b1, 1'b1, 32'h1234_0000, 3'd3}
  };

  pvd_byte_if  in_if ();
  pvd_value_if out_if ();

  prefix_varint_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #4 clk = ~clk;

  function automatic void decode_byte(input logic [7:0] data, input logic last,
                                      output logic hit, output logic [31:0] value,
                                      output logic [2:0] used);
    logic [2:0] total;
    hit = 1'b0;
    value = 32'd0;
    used = 3'd0;
    if (dec_phase == 3'd0) begin
      dec_first = data;
      if ((data & PREFIX_ONE) == 8'd0) begin
        hit = 1'b1;
        value = {24'd0, data};
        used = 3'd1;
      end else begin
        if ((data & PREFIX_THREE) == PREFIX_THREE) begin
          dec_kind = KIND_32;
          dec_partial = 32'd0;
        end else if ((data & PREFIX_TWO) == PREFIX_TWO) begin
          dec_kind = KIND_29;
          dec_partial = {27'd0, data[4:0]};
        end else begin
          dec_kind = KIND_14;
          dec_partial = {26'd0, data[5:0]};
        end
        dec_phase = 3'd1;
        if (last) begin
          // a cut 14-bit code gives back the raw first byte, the longer forms give zero
          hit = 1'b1;
          value = (dec_kind == KIND_14) ? {24'd0, dec_first} : 32'd0;
          used = 3'd1;
          dec_phase = 3'd0;
        end
      end
    end else begin
      dec_partial = {dec_partial[23:0], data};
      dec_phase = dec_phase + 3'd1;
      total = (dec_kind == KIND_14) ? LEN_14 : (dec_kind == KIND_29) ? LEN_29 : LEN_32;
      if (dec_phase >= total) begin
        hit = 1'b1;
        value = dec_partial;
        used = dec_phase;
        dec_phase = 3'd0;
      end else if (last) begin
        // missing trailing bytes count as zero
        hit = 1'b1;
        value = dec_partial << (8 * (total - dec_phase));
        used = dec_phase;
        dec_phase = 3'd0;
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                           input logic [31:0] typed_value, input logic [2:0] typed_used);
    int gap;
    logic hit;
    logic [31:0] value;
    logic [2:0] used;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= data;
    in_if.buffer_end <= last;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    decode_byte(data, last, hit, value, used);
    if (typed) begin
      expected_values.push_back('{typed_value, typed_used});
    end else if (hit) begin
      expected_values.push_back('{value, used});
    end
  endtask

  // result side: random stalls, compare each transaction with the oldest pending value
  initial begin
    int stall;
    decoded_t want;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (out_if.valid !== 1'b1) @(posedge clk);
      if (expected_values.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %h bytes_used %0d", $time, out_if.value,
                 out_if.bytes_used);
      end else begin
        want = expected_values.pop_front();
        if (out_if.value !== want.value) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, want.value, out_if.value);
        end
        if (out_if.bytes_used !== want.used) begin
          errors++;
          $display("%0t: bytes_used expected %0d actual %0d", $time, want.used,
                   out_if.bytes_used);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int random_bytes;
    int next_pause;
    int next_mode;
    int length;
    int cut;
    int noise;
    code_kind_t form;
    logic [7:0] lead;
    logic cut_last;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= 8'd0;
    in_if.buffer_end <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].value, directed_rows[i].used);
    end

    random_bytes = 0;
    next_pause = 400;
    next_mode = 300;
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes >= next_mode) begin
        // alternate busy stretches with stretches of back-to-back transactions
        idle_on = !idle_on;
        next_mode += idle_on ? 300 : 120;
      end
      if (random_bytes >= next_pause) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_values.size() != 0) @(posedge clk);
        next_pause += 400;
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary bytes that may break the current code
        noise = $urandom_range(1, 4);
        repeat (noise) begin
          send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, 32'd0, 3'd0);
          random_bytes++;
        end
      end else begin
        form = code_kind_t'($urandom_range(0, 3));
        lead = 8'($urandom);
        case (form)
          KIND_NONE: begin
            lead[7] = 1'b0;
            length = 1;
          end
          KIND_14: begin
            lead[7:6] = 2'b10;
            length = LEN_14;
          end
          KIND_29: begin
            lead[7:5] = 3'b110;
            length = LEN_29;
          end
          default: begin
            lead[7:5] = 3'b111;
            length = LEN_32;
          end
        endcase
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, length) : length;
        cut_last = (cut < length) || ($urandom_range(0, 3) == 0);
        for (int i = 1; i <= cut; i++) begin
          send_byte((i == 1) ? lead : 8'($urandom), (i == cut) && cut_last, 1'b0, 32'd0,
                    3'd0);
          random_bytes++;
        end
      end
    end

    in_if.valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
